// ===== rtl/roulette_wheel_select_assert.svh =====
// Assertion macros shared by the roulette wheel selector modules.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef ROULETTE_WHEEL_SELECT_ASSERT_SVH
`define ROULETTE_WHEEL_SELECT_ASSERT_SVH

`ifndef SYNTHESIS

`define RWS_ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: invariant violated");

`define RWS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication violated");

`define RWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");

`else

`define RWS_ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define RWS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/rws_pkg.sv =====
package rws_pkg;

  // Field widths of the item and result payloads.
  localparam int MODE_W   = 2;
  localparam int Q88_W    = 16;
  localparam int FRAC_W   = 17;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 6;

  // Weight is (Q9.8 sum) x (Q8.8 pheromone) = unsigned Q17.16.
  localparam int WEIGHT_W = 33;
  // Fractional bits of the random fraction, i.e. the scaling of the prefix.
  localparam int FRAC_Q   = 16;
  // Width of one slice of the total fed to the multiplier per cycle.
  localparam int CHUNK_W  = 16;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SELECT = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_CONN = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_CAND = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

  typedef struct packed {
    logic                load;
    logic                clear;
    logic                app_mul;
    logic                app_write;
    logic                mul_step;
    logic                walk_start;
    logic                walk_step;
    logic                res_load;
    logic                res_use_walk;
    logic [STATUS_W-1:0] res_status;
  } rws_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              count_zero;
    logic              count_one;
    logic              total_zero;
    logic              mul_done;
    logic              walk_done;
  } rws_stat_t;

endpackage

// ===== rtl/rws_in_if.sv =====
interface rws_in_if;
  logic                        valid;
  logic                        ready;
  logic [rws_pkg::MODE_W-1:0]  mode;
  logic [rws_pkg::Q88_W-1:0]   edge_heuristic;
  logic [rws_pkg::Q88_W-1:0]   node_heuristic;
  logic [rws_pkg::Q88_W-1:0]   pheromone;
  logic                        leaves_node;
  logic                        direction;
  logic [rws_pkg::FRAC_W-1:0]  random_fraction;

  modport source (
    output valid, mode, edge_heuristic, node_heuristic, pheromone,
           leaves_node, direction, random_fraction,
    input  ready
  );

  modport sink (
    input  valid, mode, edge_heuristic, node_heuristic, pheromone,
           leaves_node, direction, random_fraction,
    output ready
  );
endinterface

// ===== rtl/rws_out_if.sv =====
interface rws_out_if;
  logic                          valid;
  logic                          ready;
  logic [rws_pkg::STATUS_W-1:0]  status;
  logic [rws_pkg::INDEX_W-1:0]   selected_index;

  modport source (output valid, status, selected_index, input ready);
  modport sink   (input valid, status, selected_index, output ready);
endinterface

// ===== rtl/rws_controller.sv =====
`include "roulette_wheel_select_assert.svh"

module rws_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rws_pkg::rws_cmd_t   cmd,
  input  rws_pkg::rws_stat_t  stat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_APP_WR = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_WSTART = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0]                   state_r, state_nxt;
  logic [rws_pkg::STATUS_W-1:0] code_r, code_nxt;
  logic                         use_walk_r, use_walk_nxt;
  logic                         out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    use_walk_nxt  = use_walk_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        code_nxt     = rws_pkg::STAT_OK;
        use_walk_nxt = 1'b0;
        state_nxt    = S_RESP;
        case (stat.mode)
          rws_pkg::MODE_CLEAR: begin
            cmd.clear = 1'b1;
          end
          rws_pkg::MODE_APPEND: begin
            if (stat.full) begin
              code_nxt = rws_pkg::STAT_FULL;
            end else begin
              cmd.app_mul = 1'b1;
              state_nxt   = S_APP_WR;
            end
          end
          rws_pkg::MODE_SELECT: begin
            if (stat.count_zero) begin
              code_nxt = rws_pkg::STAT_NO_CONN;
            end else if (stat.total_zero) begin
              code_nxt = rws_pkg::STAT_NO_CAND;
            end else if (!stat.count_one) begin
              state_nxt = S_MUL;
            end
          end
          default: begin
          end
        endcase
      end
      S_APP_WR: begin
        cmd.app_write = 1'b1;
        state_nxt     = S_RESP;
      end
      S_MUL: begin
        if (stat.mul_done) begin
          state_nxt = S_WSTART;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_WSTART: begin
        cmd.walk_start = 1'b1;
        state_nxt      = S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_done) begin
          use_walk_nxt = 1'b1;
          state_nxt    = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load     = 1'b1;
          cmd.res_status   = code_r;
          cmd.res_use_walk = use_walk_r;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= rws_pkg::STAT_OK;
      use_walk_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      use_walk_r  <= use_walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted item always moves the sequencer on to decoding.
  `RWS_ASSERT_NEXT(a_accept_decodes, clk, rst_n, in_valid && in_ready, state_r == S_DECODE)
  // A result only appears after the response state.
  `RWS_ASSERT_IMPL(a_rise_from_resp, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_RESP)

endmodule

// ===== rtl/rws_datapath.sv =====
`include "roulette_wheel_select_assert.svh"

module rws_datapath #(
  parameter int MAX_EDGES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rws_pkg::rws_cmd_t             cmd,
  output rws_pkg::rws_stat_t            stat,
  input  logic [rws_pkg::MODE_W-1:0]    in_mode,
  input  logic [rws_pkg::Q88_W-1:0]     in_edge_heuristic,
  input  logic [rws_pkg::Q88_W-1:0]     in_node_heuristic,
  input  logic [rws_pkg::Q88_W-1:0]     in_pheromone,
  input  logic                          in_leaves_node,
  input  logic                          in_direction,
  input  logic [rws_pkg::FRAC_W-1:0]    in_random_fraction,
  output logic [rws_pkg::STATUS_W-1:0]  res_status,
  output logic [rws_pkg::INDEX_W-1:0]   res_selected_index
);

  localparam int IW     = $clog2(MAX_EDGES);
  localparam int CW     = $clog2(MAX_EDGES + 1);
  localparam int TOT_W  = rws_pkg::WEIGHT_W + IW;
  localparam int TGT_W  = TOT_W + rws_pkg::FRAC_W;
  localparam int NCH    = (TOT_W + rws_pkg::CHUNK_W - 1) / rws_pkg::CHUNK_W;
  localparam int PAD_W  = NCH * rws_pkg::CHUNK_W;
  localparam int MCW    = $clog2(NCH + 2);
  localparam int PROD_W = rws_pkg::CHUNK_W + rws_pkg::FRAC_W;
  localparam int MEM_W  = rws_pkg::WEIGHT_W + 1;
  localparam int HSUM_W = rws_pkg::Q88_W + 1;

  // Captured item
  logic [rws_pkg::MODE_W-1:0] mode_r;
  logic [rws_pkg::Q88_W-1:0]  eh_r, nh_r, ph_r;
  logic                       lv_r, dir_r;
  logic [rws_pkg::FRAC_W-1:0] frac_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      eh_r   <= in_edge_heuristic;
      nh_r   <= in_node_heuristic;
      ph_r   <= in_pheromone;
      lv_r   <= in_leaves_node;
      dir_r  <= in_direction;
      frac_r <= in_random_fraction;
    end
  end

  // Edge weight for an append
  logic [HSUM_W-1:0]            hsum;
  logic [rws_pkg::WEIGHT_W-1:0] weight_r;

  assign hsum = HSUM_W'(eh_r) + HSUM_W'(nh_r);

  always_ff @(posedge clk) begin
    if (cmd.app_mul) begin
      weight_r <= rws_pkg::WEIGHT_W'(hsum) * rws_pkg::WEIGHT_W'(ph_r);
    end
  end

  // Count and per-direction totals
  logic [CW-1:0]    count_r;
  logic [TOT_W-1:0] fwd_total_r, bwd_total_r, sel_total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fwd_total_r <= '0;
      bwd_total_r <= '0;
    end else if (cmd.clear) begin
      count_r     <= '0;
      fwd_total_r <= '0;
      bwd_total_r <= '0;
    end else if (cmd.app_write) begin
      count_r <= count_r + CW'(1);
      if (lv_r) begin
        fwd_total_r <= fwd_total_r + TOT_W'(weight_r);
      end else begin
        bwd_total_r <= bwd_total_r + TOT_W'(weight_r);
      end
    end
  end

  // Forward selects edges leaving the node, backward those entering it.
  assign sel_total = dir_r ? bwd_total_r : fwd_total_r;

  // Edge store: weight with the direction flag on top.
  logic [MEM_W-1:0] mem [MAX_EDGES];
  logic [MEM_W-1:0] mem_q;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    walk_idx_r;

  assign rd_addr = cmd.walk_start ? '0 : walk_idx_r + IW'(1);

  always_ff @(posedge clk) begin
    if (cmd.app_write) begin
      mem[count_r[IW-1:0]] <= {lv_r, weight_r};
    end
    mem_q <= mem[rd_addr];
  end

  // Scaled target = total x fraction, one 16-bit slice of the total per cycle.
  logic [MCW-1:0]             mul_cnt_r, chunk_sel, shift_sel;
  logic [PAD_W-1:0]           tot_pad;
  logic [rws_pkg::CHUNK_W-1:0] chunk;
  logic [PROD_W-1:0]          prod_r;
  logic [TGT_W-1:0]           target_r;

  assign tot_pad   = PAD_W'(sel_total);
  assign chunk_sel = (mul_cnt_r < MCW'(NCH)) ? mul_cnt_r : '0;
  assign chunk     = tot_pad[chunk_sel * rws_pkg::CHUNK_W +: rws_pkg::CHUNK_W];
  assign shift_sel = mul_cnt_r - MCW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_cnt_r <= '0;
    end else if (cmd.load) begin
      mul_cnt_r <= '0;
    end else if (cmd.mul_step) begin
      mul_cnt_r <= mul_cnt_r + MCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target_r <= '0;
    end else if (cmd.mul_step) begin
      prod_r <= PROD_W'(chunk) * PROD_W'(frac_r);
      if (mul_cnt_r != '0) begin
        target_r <= target_r + (TGT_W'(prod_r) << (shift_sel * rws_pkg::CHUNK_W));
      end
    end
  end

  // Prefix walk, one stored weight per cycle.
  logic [TOT_W-1:0] prefix_r, prefix_nxt;
  logic [IW-1:0]    sel_idx_r;
  logic             hit, last;

  assign prefix_nxt = (mem_q[rws_pkg::WEIGHT_W] != dir_r)
                      ? prefix_r + TOT_W'(mem_q[rws_pkg::WEIGHT_W-1:0])
                      : prefix_r;
  assign hit  = target_r < TGT_W'({prefix_nxt, {rws_pkg::FRAC_Q{1'b0}}});
  assign last = (CW'(walk_idx_r) + CW'(2)) == count_r;

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      walk_idx_r <= '0;
      prefix_r   <= '0;
    end else if (cmd.walk_step) begin
      walk_idx_r <= walk_idx_r + IW'(1);
      prefix_r   <= prefix_nxt;
      if (hit) begin
        sel_idx_r <= walk_idx_r;
      end else if (last) begin
        sel_idx_r <= walk_idx_r + IW'(1);
      end
    end
  end

  // Output register
  logic [rws_pkg::STATUS_W-1:0] res_status_r;
  logic [rws_pkg::INDEX_W-1:0]  res_index_r;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_index_r  <= cmd.res_use_walk ? rws_pkg::INDEX_W'(sel_idx_r) : '0;
    end
  end

  assign res_status         = res_status_r;
  assign res_selected_index = res_index_r;

  assign stat.mode       = mode_r;
  assign stat.full       = (count_r == CW'(MAX_EDGES));
  assign stat.count_zero = (count_r == '0);
  assign stat.count_one  = (count_r == CW'(1));
  assign stat.total_zero = (sel_total == '0);
  assign stat.mul_done   = (mul_cnt_r == MCW'(NCH + 1));
  assign stat.walk_done  = hit || last;

  `RWS_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(MAX_EDGES))
  `RWS_ASSERT_IMPL(a_no_write_full, clk, rst_n, cmd.app_write, count_r < CW'(MAX_EDGES))
  `RWS_ASSERT_IMPL(a_walk_in_list, clk, rst_n, cmd.walk_step, (CW'(walk_idx_r) + CW'(1)) < count_r)

endmodule

// ===== rtl/roulette_wheel_select.sv =====
// Channel  Dir  Payload                                                     Accepted when
// in_ch    in   mode, edge_heuristic, node_heuristic, pheromone,            valid && ready
//               leaves_node, direction, random_fraction
// out_ch   out  status, selected_index                                      valid && ready
//
// Sequence: clear, an unused mode, an append to a full list and a select that needs no walk
// go from decode straight to the response; an append also writes the edge store. A select
// over two or more edges scales the total in 16-bit slices and then walks the positions (at
// most count - 1) at one stored weight per cycle from the edge store.
// Reset is synchronous and clears the count, both totals and the sequencer, not the store.
// A result waits in the output register while the next item runs; that item's result, and
// so the input, is held back until the output register is free.

module roulette_wheel_select #(
  parameter int MAX_EDGES = 64
) (
  input logic       clk,
  input logic       rst_n,
  rws_in_if.sink    in_ch,
  rws_out_if.source out_ch
);

  // The controller sequences each item through decode, the weight product, the
  // fraction scaling and the prefix walk; the datapath holds the edge store,
  // the totals and the arithmetic. They talk only through cmd and stat.
  rws_pkg::rws_cmd_t  cmd;
  rws_pkg::rws_stat_t stat;

  rws_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath captures the item on acceptance and keeps the result in its
  // output register until the sink takes it.
  rws_datapath #(
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_mode            (in_ch.mode),
    .in_edge_heuristic  (in_ch.edge_heuristic),
    .in_node_heuristic  (in_ch.node_heuristic),
    .in_pheromone       (in_ch.pheromone),
    .in_leaves_node     (in_ch.leaves_node),
    .in_direction       (in_ch.direction),
    .in_random_fraction (in_ch.random_fraction),
    .res_status         (out_ch.status),
    .res_selected_index (out_ch.selected_index)
  );

endmodule

// ===== tb/roulette_wheel_select_tb.sv =====
`timescale 1ns / 1ps

module roulette_wheel_select_tb;

  localparam int EDGE_CAP     = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 250;
  localparam int DRAIN_CYCLES = 100;
  localparam int PICK_DEPTH   = 16;

  // Mode 3 has no function in the block; it leaves the list and the totals alone.
  localparam logic [rws_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Direction of a select, and the matching value of the stored leaves flag.
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_BWD = 1'b1;
  localparam logic LV_OUT  = 1'b1;
  localparam logic LV_IN   = 1'b0;

  // Whether a table row carries its own expected result or leaves it to the predictor.
  localparam logic FROM_TABLE     = 1'b1;
  localparam logic FROM_PREDICTOR = 1'b0;

  localparam logic [63:0] WEIGHT_MASK = (64'd1 << rws_pkg::WEIGHT_W) - 64'd1;
  localparam logic [63:0] TOTAL_MASK  = (64'd1 << 39) - 64'd1;

  typedef struct packed {
    logic [rws_pkg::MODE_W-1:0] mode;
    logic [rws_pkg::Q88_W-1:0]  eh;
    logic [rws_pkg::Q88_W-1:0]  nh;
    logic [rws_pkg::Q88_W-1:0]  ph;
    logic                       leaves;
    logic                       dir;
    logic [rws_pkg::FRAC_W-1:0] frac;
  } edge_req_t;

  typedef struct packed {
    logic [rws_pkg::STATUS_W-1:0] status;
    logic [rws_pkg::INDEX_W-1:0]  index;
  } pick_t;

  typedef struct packed {
    edge_req_t req;
    logic      source;
    pick_t     pick;
  } steer_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rws_in_if  in_ch ();
  rws_out_if out_ch ();

  roulette_wheel_select #(
    .MAX_EDGES (EDGE_CAP)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Directed opening. The first select meets an empty list, the early backward selects see
  // no backward weight at all, and the fraction of all ones drives the search past the
  // total so that it falls back to the last index. Rows whose answer is obvious carry
  // it here; the searches themselves go through the predictor.
  steer_row_t steer_table [0:20] = '{
    '{'{rws_pkg::MODE_SELECT, 16'h0000, 16'h0000, 16'h0000, LV_IN,  DIR_FWD, 17'd32768},
      FROM_TABLE, '{rws_pkg::STAT_NO_CONN, 6'd0}},
    '{'{rws_pkg::MODE_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF, LV_OUT, DIR_FWD, 17'd0},
      FROM_TABLE, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_SELECT, 16'h0000, 16'h0000, 16'h0000, LV_IN,  DIR_BWD, 17'd1000},
      FROM_TABLE, '{rws_pkg::STAT_NO_CAND, 6'd0}},
    '{'{rws_pkg::MODE_APPEND, 16'h0000, 16'h0000, 16'hFFFF, LV_IN,  DIR_FWD, 17'd0},
      FROM_TABLE, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_SELECT, 16'h0000, 16'h0000, 16'h0000, LV_IN,  DIR_BWD, 17'd65536},
      FROM_TABLE, '{rws_pkg::STAT_NO_CAND, 6'd0}},
    '{'{rws_pkg::MODE_APPEND, 16'h0100, 16'h0080, 16'h0200, LV_IN,  DIR_FWD, 17'd0},
      FROM_TABLE, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_APPEND, 16'h0000, 16'h0000, 16'h0000, LV_OUT, DIR_FWD, 17'd0},
      FROM_TABLE, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_APPEND, 16'h1234, 16'h0040, 16'h0100, LV_OUT, DIR_FWD, 17'd0},
      FROM_TABLE, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_SELECT, 16'h0000, 16'h0000, 16'h0000, LV_IN,  DIR_FWD, 17'd0},
      FROM_PREDICTOR, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_SELECT, 16'h0000, 16'h0000, 16'h0000, LV_IN,  DIR_FWD, 17'd65536},
      FROM_PREDICTOR, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_SELECT, 16'h0000, 16'h0000, 16'h0000, LV_IN,  DIR_FWD, 17'h1FFFF},
      FROM_PREDICTOR, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_SELECT, 16'h0000, 16'h0000, 16'h0000, LV_IN,  DIR_BWD, 17'd0},
      FROM_PREDICTOR, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_SELECT, 16'h0000, 16'h0000, 16'h0000, LV_IN,  DIR_BWD, 17'd65535},
      FROM_PREDICTOR, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_SELECT, 16'h0000, 16'h0000, 16'h0000, LV_IN,  DIR_BWD, 17'h1FFFF},
      FROM_PREDICTOR, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{MODE_UNUSED,          16'hFFFF, 16'hFFFF, 16'hFFFF, LV_OUT, DIR_BWD, 17'h1FFFF},
      FROM_TABLE, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF, LV_OUT, DIR_BWD, 17'h1FFFF},
      FROM_TABLE, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_SELECT, 16'h0000, 16'h0000, 16'h0000, LV_IN,  DIR_FWD, 17'd65536},
      FROM_TABLE, '{rws_pkg::STAT_NO_CONN, 6'd0}},
    '{'{rws_pkg::MODE_APPEND, 16'h0001, 16'h0000, 16'h0001, LV_OUT, DIR_FWD, 17'd0},
      FROM_TABLE, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_SELECT, 16'h0000, 16'h0000, 16'h0000, LV_IN,  DIR_FWD, 17'h1FFFF},
      FROM_PREDICTOR, '{rws_pkg::STAT_OK, 6'd0}},
    '{'{rws_pkg::MODE_SELECT, 16'h0000, 16'h0000, 16'h0000, LV_IN,  DIR_BWD, 17'd40000},
      FROM_TABLE, '{rws_pkg::STAT_NO_CAND, 6'd0}},
    '{'{rws_pkg::MODE_CLEAR,  16'h0000, 16'h0000, 16'h0000, LV_IN,  DIR_FWD, 17'd0},
      FROM_TABLE, '{rws_pkg::STAT_OK, 6'd0}}
  };

  // The predictor's own copy of the edge list and the per-direction totals.
  logic [rws_pkg::WEIGHT_W-1:0] wheel_weight [EDGE_CAP];
  logic                         wheel_leaves [EDGE_CAP];
  int                           wheel_len;
  int                           wheel_len_peak;
  logic [63:0]                  fwd_sum;
  logic [63:0]                  bwd_sum;

  // Expected results in order of acceptance, as a small ring.
  pick_t pick_fifo [PICK_DEPTH];
  int    pick_wr = 0;
  int    pick_rd = 0;

  int items_sent    = 0;
  int picks_seen    = 0;
  int fail_count    = 0;
  int status_tally [4] = '{0, 0, 0, 0};

  // Idle shares in percent, and the request for the long output hold. The receiver
  // process owns its own hold counter and only notices that a new request has come.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asks   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int quiet_cycles = 0;

  function automatic void file_pick(input pick_t p);
    pick_fifo[pick_wr % PICK_DEPTH] = p;
    pick_wr++;
  endfunction

  // Works out the result of one item and advances the predictor's list and totals.
  function automatic pick_t compute_pick(input edge_req_t r);
    pick_t       p;
    logic [63:0] w;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] total;
    logic [63:0] target;
    logic [63:0] prefix;
    logic        want_out;
    logic        hit;
    int          i;
    p.status = rws_pkg::STAT_OK;
    p.index  = '0;
    case (r.mode)
      rws_pkg::MODE_CLEAR: begin
        wheel_len = 0;
        fwd_sum   = '0;
        bwd_sum   = '0;
      end
      rws_pkg::MODE_APPEND: begin
        if (wheel_len >= EDGE_CAP) begin
          p.status = rws_pkg::STAT_FULL;
        end else begin
          a = 64'(r.eh);
          b = 64'(r.nh);
          c = 64'(r.ph);
          w = ((a + b) * c) & WEIGHT_MASK;
          wheel_weight[wheel_len] = w[rws_pkg::WEIGHT_W-1:0];
          wheel_leaves[wheel_len] = r.leaves;
          wheel_len = wheel_len + 1;
          if (wheel_len > wheel_len_peak) wheel_len_peak = wheel_len;
          if (r.leaves == LV_OUT) fwd_sum = (fwd_sum + w) & TOTAL_MASK;
          else bwd_sum = (bwd_sum + w) & TOTAL_MASK;
        end
      end
      rws_pkg::MODE_SELECT: begin
        // A forward select walks the edges that leave this node, a backward one the rest.
        want_out = (r.dir == DIR_FWD) ? LV_OUT : LV_IN;
        total    = (want_out == LV_OUT) ? fwd_sum : bwd_sum;
        if (wheel_len == 0) begin
          p.status = rws_pkg::STAT_NO_CONN;
        end else if (total == 0) begin
          p.status = rws_pkg::STAT_NO_CAND;
        end else begin
          c      = 64'(r.frac);
          target = total * c;
          prefix = '0;
          hit    = 1'b0;
          i      = 0;
          // Stops at the first prefix above the scaled total, else at the last position.
          while (!hit && (i + 1 < wheel_len)) begin
            if (wheel_leaves[i] == want_out) prefix = prefix + 64'(wheel_weight[i]);
            if (target < (prefix << rws_pkg::FRAC_Q)) hit = 1'b1;
            else i = i + 1;
          end
          p.index = i[rws_pkg::INDEX_W-1:0];
        end
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  function automatic logic [rws_pkg::Q88_W-1:0] draw_q88();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return rws_pkg::Q88_W'($urandom_range(0, 65535));
  endfunction

  // Mostly fractions within [0,1], with the two ends and values above one mixed in.
  function automatic logic [rws_pkg::FRAC_W-1:0] draw_frac();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return 17'd65536;
    if (pick < 5) return rws_pkg::FRAC_W'($urandom_range(0, 131071));
    return rws_pkg::FRAC_W'($urandom_range(0, 65536));
  endfunction

  function automatic edge_req_t draw_req(input logic [rws_pkg::MODE_W-1:0] mode,
                                         input int out_pct);
    edge_req_t r;
    r.mode   = mode;
    r.eh     = draw_q88();
    r.nh     = draw_q88();
    r.ph     = draw_q88();
    r.leaves = ($urandom_range(0, 99) < out_pct) ? LV_OUT : LV_IN;
    r.dir    = 1'($urandom_range(0, 1));
    r.frac   = draw_frac();
    return r;
  endfunction

  // Offers one item, holding it until the block takes it, then files the expected
  // result. The valid line is only lowered when a gap is actually drawn, so it never
  // gets two assignments in the same time step.
  task automatic offer(input edge_req_t r, input logic source, input pick_t table_pick);
    pick_t p;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_ch.valid           <= 1'b1;
    in_ch.mode            <= r.mode;
    in_ch.edge_heuristic  <= r.eh;
    in_ch.node_heuristic  <= r.nh;
    in_ch.pheromone       <= r.ph;
    in_ch.leaves_node     <= r.leaves;
    in_ch.direction       <= r.dir;
    in_ch.random_fraction <= r.frac;
    do @(posedge clk); while (!in_ch.ready);
    p = compute_pick(r);
    file_pick((source == FROM_TABLE) ? table_pick : p);
    items_sent++;
  endtask

  // A well-formed run: clear, fill with edges of a chosen direction mix, and select
  // along the way and at the end. Lengths past the capacity provoke the full status.
  task automatic run_episode(input int n_edges);
    int out_pct;
    int k;
    case ($urandom_range(0, 4))
      0:       out_pct = 0;
      1:       out_pct = 100;
      2:       out_pct = 80;
      3:       out_pct = 20;
      default: out_pct = 50;
    endcase
    offer(draw_req(rws_pkg::MODE_CLEAR, out_pct), FROM_PREDICTOR, '0);
    for (k = 0; k < n_edges; k++) begin
      offer(draw_req(rws_pkg::MODE_APPEND, out_pct), FROM_PREDICTOR, '0);
      if ($urandom_range(0, 99) < 40) begin
        offer(draw_req(rws_pkg::MODE_SELECT, out_pct), FROM_PREDICTOR, '0);
      end
    end
    repeat ($urandom_range(2, 6)) begin
      offer(draw_req(rws_pkg::MODE_SELECT, out_pct), FROM_PREDICTOR, '0);
    end
  endtask

  // Receiver: random stalls at the current share, overridden by a long hold on request.
  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen    <= hold_asks;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Result checker: each accepted result against the oldest outstanding expectation.
  always @(posedge clk) begin
    pick_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pick_wr == pick_rd) begin
        $error("unexpected result: status %0d, selected_index %0d",
               out_ch.status, out_ch.selected_index);
        fail_count++;
      end else begin
        want = pick_fifo[pick_rd % PICK_DEPTH];
        pick_rd++;
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.selected_index !== want.index) begin
          $error("selected_index: expected %0d, got %0d", want.index, out_ch.selected_index);
          fail_count++;
        end
        picks_seen++;
        status_tally[want.status]++;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int row;
    int phase;
    int goal;
    int size_pick;
    logic full_done;
    wheel_len      = 0;
    wheel_len_peak = 0;
    fwd_sum        = '0;
    bwd_sum        = '0;

    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.mode            = rws_pkg::MODE_CLEAR;
    in_ch.edge_heuristic  = '0;
    in_ch.node_heuristic  = '0;
    in_ch.pheromone       = '0;
    in_ch.leaves_node     = LV_IN;
    in_ch.direction       = DIR_FWD;
    in_ch.random_fraction = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < $size(steer_table); row++) begin
      offer(steer_table[row].req, steer_table[row].source, steer_table[row].pick);
    end

    // Three phases: a slow receiver, then a slow sender, then both at full rate with
    // one long output hold at the start so that the block backs up into its input.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 28;
          rx_idle_pct <= 88;
        end
        1: begin
          tx_idle_pct = 88;
          rx_idle_pct <= 28;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
          hold_asks   <= hold_asks + 1;
        end
      endcase
      goal      = items_sent + PHASE_ITEMS;
      full_done = 1'b0;
      while (items_sent < goal) begin
        if (!full_done && (items_sent > goal - 150)) begin
          run_episode(EDGE_CAP + $urandom_range(1, 3));
          full_done = 1'b1;
        end else if ($urandom_range(0, 99) < 10) begin
          // Stray items of any mode, breaking into whatever list is standing.
          repeat ($urandom_range(1, 4)) begin
            offer(draw_req(rws_pkg::MODE_W'($urandom_range(0, 3)), 50), FROM_PREDICTOR, '0);
          end
        end else begin
          size_pick = $urandom_range(0, 99);
          if (size_pick < 80) run_episode($urandom_range(1, 8));
          else if (size_pick < 95) run_episode($urandom_range(9, 32));
          else run_episode($urandom_range(33, EDGE_CAP - 1));
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pick_wr != pick_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items, checked %0d results: %0d ok, %0d empty list, %0d no candidates,",
             items_sent, picks_seen, status_tally[rws_pkg::STAT_OK],
             status_tally[rws_pkg::STAT_NO_CONN], status_tally[rws_pkg::STAT_NO_CAND]);
    $display("%0d list full; list grew to %0d edges under turn-about stalls and a %0d-cycle hold.",
             status_tally[rws_pkg::STAT_FULL], wheel_len_peak, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rws_pkg.sv
rtl/rws_in_if.sv
rtl/rws_out_if.sv
rtl/rws_controller.sv
rtl/rws_datapath.sv
rtl/roulette_wheel_select.sv
tb/roulette_wheel_select_tb.sv
